/* src/cqf_pkg.sv */
// shared constants, types and the coefficient index decoder for the 3x3 conv core
// no dependencies
`default_nettype none

package cqf_pkg;

    localparam int IMG_SIZE_DEF = 28;
    localparam int NUM_FILTERS  = 8;
    localparam int DATA_W       = 16;
    localparam int KSIZE        = 3;
    localparam int TAPS         = KSIZE * KSIZE;
    localparam int NUM_WEIGHTS  = NUM_FILTERS * TAPS;
    localparam int NUM_COEFS    = NUM_WEIGHTS + NUM_FILTERS;
    localparam int IDX_W        = 7;
    localparam int FID_W        = 3;
    localparam int TAP_W        = 4;
    localparam int POS_W        = 5;
    localparam int SHIFT_W      = 4;
    localparam int PROD_W       = 2 * DATA_W;
    localparam int SUM3_W       = PROD_W + 2;
    localparam int SUM_W        = PROD_W + 4;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [SHIFT_W-1:0] FRAC_SHIFT_RST = SHIFT_W'(8);
    localparam logic               REG_FRAC_SHIFT = 1'b0;

    typedef enum logic {
        FUNC_COEF  = 1'b0,
        FUNC_PIXEL = 1'b1
    } func_t;

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef sample_t [TAPS-1:0] window_t;

    typedef struct packed {
        window_t          win;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last_px;
    } job_t;

    typedef struct packed {
        logic             is_weight;
        logic             is_bias;
        logic [FID_W-1:0] filt;
        logic [TAP_W-1:0] tap;
    } coef_dec_t;

    typedef struct packed {
        logic             we_weight;
        logic             we_bias;
        logic [FID_W-1:0] filt;
        logic [TAP_W-1:0] tap;
        sample_t          value;
    } coef_wr_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } q_stat_t;

    typedef struct packed {
        logic idle;
    } back_stat_t;

    // weight index f*9+t splits into filter and tap, biases follow the weights
    function automatic coef_dec_t coef_decode(logic [IDX_W-1:0] idx);
        coef_dec_t d;
        d = '0;
        if (idx >= IDX_W'(NUM_WEIGHTS))
        begin
            if (idx < IDX_W'(NUM_COEFS))
            begin
                d.is_bias = 1'b1;
                d.filt    = FID_W'(idx - IDX_W'(NUM_WEIGHTS));
            end
        end
        else
        begin
            d.is_weight = 1'b1;
            for (int f = 0; f < NUM_FILTERS; f++)
            begin
                if (idx >= IDX_W'(f * TAPS))
                begin
                    d.filt = FID_W'(f);
                    d.tap  = TAP_W'(idx - IDX_W'(f * TAPS));
                end
            end
        end
        return d;
    endfunction

endpackage

`default_nettype wire

/* src/cqf_if.sv */
// request channel interfaces: item input and result output of the conv core
// depends on cqf_pkg
`default_nettype none

interface cqf_in_if import cqf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             func;
    logic [IDX_W-1:0] coef_index;
    sample_t          coef_value;
    sample_t          pixel;

    modport source (output valid, output func, output coef_index, output coef_value,
                    output pixel, input ready);
    modport sink   (input valid, input func, input coef_index, input coef_value,
                    input pixel, output ready);
endinterface

interface cqf_out_if import cqf_pkg::*; ();
    logic             valid;
    logic             ready;
    sample_t          conv_value;
    logic [FID_W-1:0] filter_id;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             last_of_run;
    logic             frame_end;

    modport source (output valid, output conv_value, output filter_id, output out_row,
                    output out_col, output last_of_run, output frame_end, input ready);
    modport sink   (input valid, input conv_value, input filter_id, input out_row,
                    input out_col, input last_of_run, input frame_end, output ready);
endinterface

`default_nettype wire

/* src/cqf_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module cqf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* src/cqf_front.sv */
// front part: accepts requests, tracks raster position, keeps line store and window,
// issues coefficient writes and queues complete windows; depends on cqf_pkg, cqf_if, cqf_ram
`default_nettype none

module cqf_front import cqf_pkg::*; #(
    parameter int IMG_SIZE = IMG_SIZE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    cqf_in_if.sink     items,
    input  q_stat_t    q_stat,
    input  back_stat_t b_stat,
    output logic       push,
    output job_t       push_job,
    output coef_wr_t   coef_wr
);

    localparam int CNT_W = $clog2(IMG_SIZE);
    localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(IMG_SIZE - 1);
    localparam logic [CNT_W-1:0] FIRST_FULL = CNT_W'(KSIZE - 1);

    logic [CNT_W-1:0]  row_reg;
    logic [CNT_W-1:0]  col_reg;
    logic              p1_valid_reg;
    logic              p1_pixel_reg;
    sample_t           p1_px_reg;
    logic [CNT_W-1:0]  p1_row_reg;
    logic [CNT_W-1:0]  p1_col_reg;
    logic [IDX_W-1:0]  p1_idx_reg;
    sample_t           p1_value_reg;
    window_t           win_reg;
    window_t           win_next;
    logic [2*DATA_W-1:0] line_rd;
    logic [QCNT_W:0]   occupancy;
    logic              room;
    logic              drained;
    logic              accept;
    logic              is_pixel;
    logic              p1_is_px;
    logic [PW-1:0]     row_off;
    logic [PW-1:0]     col_off;
    coef_dec_t         dec;

    assign is_pixel  = (items.func == FUNC_PIXEL);
    assign occupancy = {1'b0, q_stat.count} + (QCNT_W + 1)'(p1_valid_reg);
    assign room      = (occupancy < (QCNT_W + 1)'(QUEUE_DEPTH));
    // coefficients may only change once every queued window has been used
    assign drained   = q_stat.empty && !p1_valid_reg && b_stat.idle;
    assign items.ready = is_pixel ? room : drained;
    assign accept    = items.valid && items.ready;
    assign p1_is_px  = p1_valid_reg && p1_pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= accept;
            if (accept && is_pixel)
            begin
                if (col_reg == LAST_POS)
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg == LAST_POS) ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_pixel_reg <= is_pixel;
            p1_px_reg    <= items.pixel;
            p1_row_reg   <= row_reg;
            p1_col_reg   <= col_reg;
            p1_idx_reg   <= items.coef_index;
            p1_value_reg <= items.coef_value;
        end
        if (p1_is_px)
        begin
            win_reg <= win_next;
        end
    end

    // line entry holds the two stored rows, older row in the low half
    cqf_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (IMG_SIZE)
    ) u_line_ram (
        .clk   (clk),
        .we    (p1_is_px),
        .waddr (p1_col_reg),
        .wdata ({p1_px_reg, line_rd[2*DATA_W-1:DATA_W]}),
        .re    (accept && is_pixel),
        .raddr (col_reg),
        .rdata (line_rd)
    );

    always_comb
    begin
        win_next = win_reg;
        for (int k = 0; k < KSIZE; k++)
        begin
            win_next[k*KSIZE]     = win_reg[k*KSIZE + 1];
            win_next[k*KSIZE + 1] = win_reg[k*KSIZE + 2];
        end
        win_next[KSIZE-1]   = line_rd[DATA_W-1:0];
        win_next[2*KSIZE-1] = line_rd[2*DATA_W-1:DATA_W];
        win_next[TAPS-1]    = p1_px_reg;
    end

    assign row_off = PW'(p1_row_reg) - PW'(KSIZE - 1);
    assign col_off = PW'(p1_col_reg) - PW'(KSIZE - 1);

    assign push = p1_is_px && (p1_row_reg >= FIRST_FULL) && (p1_col_reg >= FIRST_FULL);
    assign push_job.win     = win_next;
    assign push_job.row     = row_off[POS_W-1:0];
    assign push_job.col     = col_off[POS_W-1:0];
    assign push_job.last_px = (p1_row_reg == LAST_POS) && (p1_col_reg == LAST_POS);

    assign dec = coef_decode(p1_idx_reg);
    assign coef_wr.we_weight = p1_valid_reg && !p1_pixel_reg && dec.is_weight;
    assign coef_wr.we_bias   = p1_valid_reg && !p1_pixel_reg && dec.is_bias;
    assign coef_wr.filt      = dec.filt;
    assign coef_wr.tap       = dec.tap;
    assign coef_wr.value     = p1_value_reg;

endmodule

`default_nettype wire

/* src/cqf_queue.sv */
// short window queue between the front and back parts
// depends on cqf_pkg
`default_nettype none

module cqf_queue import cqf_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head_job,
    output q_stat_t q_stat
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job     = slot_reg[rd_ptr_reg];
    assign q_stat.count = count_reg;
    assign q_stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

/* src/cqf_back.sv */
// back part: coefficient stores, per-filter sequencer, multiply and adder pipeline,
// output register; depends on cqf_pkg, cqf_if, cqf_ram
`default_nettype none

module cqf_back import cqf_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  q_stat_t            q_stat,
    input  job_t               head_job,
    output logic               pop,
    input  coef_wr_t           coef_wr,
    input  logic [SHIFT_W-1:0] frac_shift,
    cqf_out_if.source          results,
    output back_stat_t         b_stat
);

    typedef struct packed {
        logic [FID_W-1:0] filt;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last_px;
    } meta_t;

    localparam logic [FID_W-1:0] LAST_FILT = FID_W'(NUM_FILTERS - 1);

    logic                     adv;
    logic                     seq_active_reg;
    logic [FID_W-1:0]         f_reg;
    job_t                     cur_job_reg;
    window_t                  w_rdata;
    sample_t                  b_rdata;

    logic                     b1_v_reg;
    window_t                  b1_win_reg;
    meta_t                    b1_meta_reg;
    logic                     b2_v_reg;
    logic signed [PROD_W-1:0] b2_prod_reg [TAPS];
    sample_t                  b2_bias_reg;
    meta_t                    b2_meta_reg;
    logic                     b3_v_reg;
    logic signed [SUM3_W-1:0] b3_sum_reg [KSIZE];
    sample_t                  b3_bias_reg;
    meta_t                    b3_meta_reg;
    logic                     b4_v_reg;
    logic signed [SUM_W-1:0]  b4_sum_reg;
    sample_t                  b4_bias_reg;
    meta_t                    b4_meta_reg;

    logic signed [SUM_W-1:0]  shifted;
    logic signed [SUM_W-1:0]  biased;

    logic                     out_valid_reg;
    sample_t                  out_value_reg;
    meta_t                    out_meta_reg;

    // whole pipeline holds while a result waits in the output register
    assign adv = !out_valid_reg || results.ready;
    assign pop = adv && !q_stat.empty && (!seq_active_reg || f_reg == LAST_FILT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_active_reg <= 1'b0;
            f_reg          <= '0;
            b1_v_reg       <= 1'b0;
            b2_v_reg       <= 1'b0;
            b3_v_reg       <= 1'b0;
            b4_v_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            if (seq_active_reg && f_reg != LAST_FILT)
            begin
                f_reg <= f_reg + 1'b1;
            end
            else
            begin
                seq_active_reg <= pop;
                f_reg          <= '0;
            end
            b1_v_reg      <= seq_active_reg;
            b2_v_reg      <= b1_v_reg;
            b3_v_reg      <= b2_v_reg;
            b4_v_reg      <= b3_v_reg;
            out_valid_reg <= b4_v_reg;
        end
    end

    // one weight store per tap so a filter's nine weights come out together
    for (genvar t = 0; t < TAPS; t++)
    begin : g_weight
        cqf_ram #(
            .WIDTH (DATA_W),
            .DEPTH (NUM_FILTERS)
        ) u_weight_ram (
            .clk   (clk),
            .we    (coef_wr.we_weight && (coef_wr.tap == TAP_W'(t))),
            .waddr (coef_wr.filt),
            .wdata (coef_wr.value),
            .re    (adv && seq_active_reg),
            .raddr (f_reg),
            .rdata (w_rdata[t])
        );
    end

    cqf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_FILTERS)
    ) u_bias_ram (
        .clk   (clk),
        .we    (coef_wr.we_bias),
        .waddr (coef_wr.filt),
        .wdata (coef_wr.value),
        .re    (adv && seq_active_reg),
        .raddr (f_reg),
        .rdata (b_rdata)
    );

    assign shifted = b4_sum_reg >>> frac_shift;
    assign biased  = shifted + SUM_W'(b4_bias_reg);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_job_reg <= head_job;
        end
        if (adv)
        begin
            b1_win_reg          <= cur_job_reg.win;
            b1_meta_reg.filt    <= f_reg;
            b1_meta_reg.row     <= cur_job_reg.row;
            b1_meta_reg.col     <= cur_job_reg.col;
            b1_meta_reg.last_px <= cur_job_reg.last_px;

            for (int t = 0; t < TAPS; t++)
            begin
                b2_prod_reg[t] <= $signed(b1_win_reg[t]) * $signed(w_rdata[t]);
            end
            b2_bias_reg <= b_rdata;
            b2_meta_reg <= b1_meta_reg;

            for (int j = 0; j < KSIZE; j++)
            begin
                b3_sum_reg[j] <= SUM3_W'(b2_prod_reg[j*KSIZE])
                               + SUM3_W'(b2_prod_reg[j*KSIZE + 1])
                               + SUM3_W'(b2_prod_reg[j*KSIZE + 2]);
            end
            b3_bias_reg <= b2_bias_reg;
            b3_meta_reg <= b2_meta_reg;

            b4_sum_reg  <= SUM_W'(b3_sum_reg[0]) + SUM_W'(b3_sum_reg[1])
                         + SUM_W'(b3_sum_reg[2]);
            b4_bias_reg <= b3_bias_reg;
            b4_meta_reg <= b3_meta_reg;

            // wrap to the sample width
            out_value_reg <= biased[DATA_W-1:0];
            out_meta_reg  <= b4_meta_reg;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.conv_value  = out_value_reg;
    assign results.filter_id   = out_meta_reg.filt;
    assign results.out_row     = out_meta_reg.row;
    assign results.out_col     = out_meta_reg.col;
    assign results.last_of_run = (out_meta_reg.filt == LAST_FILT);
    assign results.frame_end   = (out_meta_reg.filt == LAST_FILT) && out_meta_reg.last_px;

    assign b_stat.idle = !seq_active_reg && !b1_v_reg && !b2_v_reg && !b3_v_reg && !b4_v_reg;

endmodule

`default_nettype wire

/* src/conv3x3_q8_multi_filter_core.sv */
// Valid 3x3 convolution of a square raster image against eight filters, giving eight
// results (one per filter) for every pixel that completes a window, position-major.
// A completing pixel is worked off by the back part's sequencer at one filter result
// per cycle while the output register is not stalled; other pixels skip the back part.
// A pixel's data passes the front input register, the window queue, the back job
// register, stages b1 to b4 and the output register. A coefficient load is held off
// until every queued window has left the multiply pipeline; a further load right
// behind it waits until the first has been written to its store.
// frac_shift answers at byte addresses 0 to 3 of the register port.
// Depends on cqf_pkg, cqf_if, cqf_ram, cqf_front, cqf_queue, cqf_back.
`default_nettype none

module conv3x3_q8_multi_filter_core import cqf_pkg::*; #(
    parameter int IMG_SIZE = IMG_SIZE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    cqf_in_if.sink                items,
    cqf_out_if.source             results,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [SHIFT_W-1:0] frac_shift_reg;
    logic               reg_hit;
    logic               push;
    job_t               push_job;
    logic               pop;
    job_t               head_job;
    q_stat_t            q_stat;
    back_stat_t         b_stat;
    coef_wr_t           coef_wr;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1] == REG_FRAC_SHIFT);
    assign prdata  = reg_hit ? APB_DATA_W'(frac_shift_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_shift_reg <= FRAC_SHIFT_RST;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            frac_shift_reg <= pwdata[SHIFT_W-1:0];
        end
    end

    cqf_front #(
        .IMG_SIZE (IMG_SIZE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .q_stat   (q_stat),
        .b_stat   (b_stat),
        .push     (push),
        .push_job (push_job),
        .coef_wr  (coef_wr)
    );

    cqf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    cqf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .head_job   (head_job),
        .pop        (pop),
        .coef_wr    (coef_wr),
        .frac_shift (frac_shift_reg),
        .results    (results),
        .b_stat     (b_stat)
    );

`ifndef SYNTH
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("window queue overfilled");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("window queue popped while empty");

    a_coef_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (items.valid && items.ready && items.func == FUNC_COEF)
            |-> (q_stat.empty && b_stat.idle))
        else $error("coefficient request taken while windows still in flight");

    a_last_filter: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.last_of_run == (results.filter_id == FID_W'(NUM_FILTERS - 1))))
        else $error("last_of_run does not match the final filter");
`endif

endmodule

`default_nettype wire
